@@ design/stok_pkg.sv @@
// ============================================================================
// stok_pkg: shared types, constants and helpers for the source tokenizer
// Token kinds, character codes, scan modes, the token record and the
// character classification used by the lexer.
// ============================================================================
package stok_pkg;

    // Position and length counters
    localparam int POS_WIDTH = 16;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    // Output queue geometry
    localparam int QDEPTH  = 4;
    localparam int Q_IDX_W = $clog2(QDEPTH);
    localparam int Q_CNT_W = $clog2(QDEPTH + 1);

    // Token kinds
    localparam logic [5:0] K_LBRACE  = 6'd0;
    localparam logic [5:0] K_RBRACE  = 6'd1;
    localparam logic [5:0] K_LPAREN  = 6'd2;
    localparam logic [5:0] K_RPAREN  = 6'd3;
    localparam logic [5:0] K_LBRACK  = 6'd4;
    localparam logic [5:0] K_RBRACK  = 6'd5;
    localparam logic [5:0] K_COLON   = 6'd6;
    localparam logic [5:0] K_ASSIGN  = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_AMP     = 6'd9;
    localparam logic [5:0] K_COMMA   = 6'd10;
    localparam logic [5:0] K_PIPE    = 6'd11;
    localparam logic [5:0] K_EQ      = 6'd12;
    localparam logic [5:0] K_EQEQ    = 6'd13;
    localparam logic [5:0] K_MINUS   = 6'd14;
    localparam logic [5:0] K_ARROW   = 6'd15;
    localparam logic [5:0] K_PLUS    = 6'd16;
    localparam logic [5:0] K_STAR    = 6'd17;
    localparam logic [5:0] K_SLASH   = 6'd18;
    localparam logic [5:0] K_PERCENT = 6'd19;
    localparam logic [5:0] K_BANG    = 6'd20;
    localparam logic [5:0] K_NE      = 6'd21;
    localparam logic [5:0] K_LT      = 6'd22;
    localparam logic [5:0] K_LE      = 6'd23;
    localparam logic [5:0] K_GT      = 6'd24;
    localparam logic [5:0] K_GE      = 6'd25;
    localparam logic [5:0] K_STRING  = 6'd26;
    localparam logic [5:0] K_INT     = 6'd27;
    localparam logic [5:0] K_IDENT   = 6'd28;
    localparam logic [5:0] K_FUNC    = 6'd29;
    localparam logic [5:0] K_RET     = 6'd30;
    localparam logic [5:0] K_IF      = 6'd31;
    localparam logic [5:0] K_ELSE    = 6'd32;
    localparam logic [5:0] K_EOF     = 6'd33;
    localparam logic [5:0] K_BADCHAR = 6'd34;
    localparam logic [5:0] K_UNTERM  = 6'd35;
    localparam logic [5:0] K_NONE    = 6'h3F;

    // Character codes
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_QUOTE      = 8'h22;

    // Keyword spellings, first byte highest
    localparam logic [31:0] KW_FUNC = 32'h66756E63;
    localparam logic [23:0] KW_RET  = 24'h726574;
    localparam logic [15:0] KW_IF   = 16'h6966;
    localparam logic [31:0] KW_ELSE = 32'h656C7365;

    typedef enum logic [3:0] {
        SCAN_IDLE  = 4'd0,
        SCAN_OP    = 4'd1,
        SCAN_IDENT = 4'd2,
        SCAN_INT   = 4'd3,
        SCAN_STR   = 4'd4
    } scan_mode_t;

    typedef enum logic [2:0] {
        CC_SPACE,
        CC_SINGLE,
        CC_OP,
        CC_QUOTE,
        CC_ALPHA,
        CC_DIGIT,
        CC_BAD
    } char_class_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } token_t;

    // Up to two tokens produced by one input beat
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } stok_emit_t;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + POS_WIDTH'(1);
    endfunction

    function automatic logic [15:0] out16(input logic [POS_WIDTH-1:0] v);
        return 16'(v);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h7B: k = K_LBRACE;
            8'h7D: k = K_RBRACE;
            8'h28: k = K_LPAREN;
            8'h29: k = K_RPAREN;
            8'h5B: k = K_LBRACK;
            8'h5D: k = K_RBRACK;
            8'h3B: k = K_SEMI;
            8'h26: k = K_AMP;
            8'h2C: k = K_COMMA;
            8'h7C: k = K_PIPE;
            8'h2B: k = K_PLUS;
            8'h2A: k = K_STAR;
            8'h2F: k = K_SLASH;
            8'h25: k = K_PERCENT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Operators that may take a second character
    function automatic logic [5:0] op_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h3A: k = K_COLON;
            8'h3D: k = K_EQ;
            8'h2D: k = K_MINUS;
            8'h21: k = K_BANG;
            8'h3C: k = K_LT;
            8'h3E: k = K_GT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cc;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            cc = CC_SPACE;
        end else if (single_kind(c) != K_NONE) begin
            cc = CC_SINGLE;
        end else if (op_kind(c) != K_NONE) begin
            cc = CC_OP;
        end else if (c == CH_QUOTE) begin
            cc = CC_QUOTE;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
            cc = CC_ALPHA;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cc = CC_DIGIT;
        end else begin
            cc = CC_BAD;
        end
        return cc;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [POS_WIDTH-1:0] len,
                                              input logic [31:0] win);
        logic [5:0] k;
        if (len == POS_WIDTH'(4) && win == KW_FUNC) begin
            k = K_FUNC;
        end else if (len == POS_WIDTH'(3) && win[23:0] == KW_RET) begin
            k = K_RET;
        end else if (len == POS_WIDTH'(2) && win[15:0] == KW_IF) begin
            k = K_IF;
        end else if (len == POS_WIDTH'(4) && win == KW_ELSE) begin
            k = K_ELSE;
        end else begin
            k = K_IDENT;
        end
        return k;
    endfunction

endpackage

@@ design/source_tokenizer.sv @@
// ============================================================================
// source_tokenizer: streaming lexical analyzer
// Turns a byte stream of source text into tokens of kind, start, length, line.
// ============================================================================
// Usage:
//   The slave channel carries one source byte per beat in s_tdata[7:0]; a
//   beat with s_tlast high closes the text and its byte is ignored. The
//   master channel carries one token per beat; m_tlast marks the final token
//   caused by one input beat.
//   Tokens completed by an input beat are registered into the result queue
//   when that beat is accepted and reach the master side from its head.
//   Throughput: one byte per cycle. A byte completes at most two tokens; the
//   four-entry result queue drains one token per cycle, and s_tready drops
//   while more than two tokens wait in it, so a long run of double results
//   slows intake to the master side's drain rate.
//   Reset: aresetn low for one clock clears the queue and returns the scanner
//   to position 0, line 1. The scanner returns to that state after each end beat.
//   Stall: while m_tready is low the head token holds; the scanner keeps
//   taking bytes until the queue is nearly full.
// ============================================================================
module source_tokenizer import stok_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [5:0] token_kind, [21:6] token_start,
                                   // [37:22] token_length, [53:38] line_number
    output logic        m_tlast    // last_of_run
);

    logic       in_fire;
    stok_emit_t emit;
    token_t     head_tok;

    assign in_fire = s_tvalid && s_tready;

    stok_lexer u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .char_code  (s_tdata),
        .end_marker (s_tlast),
        .emit       (emit)
    );

    stok_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_fire),
        .wr_data  (emit),
        .wr_ready (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_tok   (head_tok)
    );

    // Pack the head token onto the master beat
    assign m_tdata = {2'b00, head_tok.line, head_tok.length, head_tok.start, head_tok.kind};
    assign m_tlast = head_tok.last;

endmodule

@@ design/stok_lexer.sv @@
// ============================================================================
// stok_lexer: scan state and token decision
// Holds the scan mode, position, lexeme and line registers, and decides for
// each accepted byte the zero, one or two tokens it completes.
// ============================================================================
module stok_lexer import stok_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] char_code,
    input  logic       end_marker,
    output stok_emit_t emit
);

    scan_mode_t            mode_reg, mode_next;
    logic [POS_WIDTH-1:0]  pos_reg, pos_next;
    logic [POS_WIDTH-1:0]  start_reg, start_next;
    logic [POS_WIDTH-1:0]  len_reg, len_next;
    logic [31:0]           window_reg, window_next;
    logic [15:0]           line_reg, line_next;

    char_class_t cls;
    logic        ident_ch;
    logic        op_pair;
    logic        do_start;
    logic [7:0]  need_ch;

    logic                 pend_vld, sc_vld;
    logic [5:0]           pend_kind, sc_kind;
    logic [POS_WIDTH-1:0] pend_len, sc_len, sc_start;
    token_t               pend_tok, sc_tok;

    // Byte classification and whether the byte opens a fresh lexeme
    always_comb begin
        cls      = classify(char_code);
        ident_ch = (cls == CC_ALPHA) || (cls == CC_DIGIT) || (char_code == CH_UNDERSCORE);
        need_ch  = (window_reg[5:0] == K_MINUS) ? CH_GT : CH_EQ;
        op_pair  = (char_code == need_ch);
        case (mode_reg)
            SCAN_OP:    do_start = !op_pair;
            SCAN_IDENT: do_start = !ident_ch;
            SCAN_INT:   do_start = (cls != CC_DIGIT);
            SCAN_STR:   do_start = 1'b0;
            default:    do_start = 1'b1;
        endcase
        do_start = do_start && !end_marker;
    end

    // Next scan state
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        window_next = window_reg;
        line_next   = line_reg;
        if (end_marker) begin
            mode_next   = SCAN_IDLE;
            pos_next    = '0;
            start_next  = '0;
            len_next    = '0;
            window_next = '0;
            line_next   = 16'd1;
        end else begin
            pos_next = sat_inc(pos_reg);
            case (mode_reg)
                SCAN_OP: begin
                    mode_next   = SCAN_IDLE;
                    window_next = '0;
                end
                SCAN_IDENT: begin
                    if (ident_ch) begin
                        len_next    = sat_inc(len_reg);
                        window_next = {window_reg[23:0], char_code};
                    end else begin
                        mode_next = SCAN_IDLE;
                    end
                end
                SCAN_INT: begin
                    if (cls == CC_DIGIT) begin
                        len_next = sat_inc(len_reg);
                    end else begin
                        mode_next = SCAN_IDLE;
                    end
                end
                SCAN_STR: begin
                    if (char_code == CH_QUOTE) begin
                        mode_next = SCAN_IDLE;
                    end else begin
                        len_next = sat_inc(len_reg);
                    end
                end
                default: mode_next = SCAN_IDLE;
            endcase
            if (do_start) begin
                case (cls)
                    CC_SPACE: begin
                        if (char_code == CH_NL && line_reg < LINE_MAX) begin
                            line_next = line_reg + 16'd1;
                        end
                    end
                    CC_OP: begin
                        mode_next   = SCAN_OP;
                        start_next  = pos_reg;
                        window_next = {26'd0, op_kind(char_code)};
                    end
                    CC_QUOTE: begin
                        mode_next  = SCAN_STR;
                        start_next = sat_inc(pos_reg);
                        len_next   = '0;
                    end
                    CC_ALPHA, CC_DIGIT: begin
                        mode_next   = (cls == CC_ALPHA) ? SCAN_IDENT : SCAN_INT;
                        start_next  = pos_reg;
                        len_next    = POS_WIDTH'(1);
                        window_next = {24'd0, char_code};
                    end
                    default: ;
                endcase
            end
        end
    end

    // Tokens completed by this beat: the pending lexeme, then the new one
    always_comb begin
        pend_vld  = 1'b0;
        pend_kind = K_NONE;
        pend_len  = len_reg;
        case (mode_reg)
            SCAN_OP: begin
                pend_vld  = 1'b1;
                pend_kind = (!end_marker && op_pair) ? window_reg[5:0] + 6'd1
                                                     : window_reg[5:0];
                pend_len  = (!end_marker && op_pair) ? POS_WIDTH'(2) : POS_WIDTH'(1);
            end
            SCAN_IDENT: begin
                pend_vld  = end_marker || !ident_ch;
                pend_kind = ident_kind(len_reg, window_reg);
            end
            SCAN_INT: begin
                pend_vld  = end_marker || (cls != CC_DIGIT);
                pend_kind = K_INT;
            end
            SCAN_STR: begin
                pend_vld  = end_marker || (char_code == CH_QUOTE);
                pend_kind = end_marker ? K_UNTERM : K_STRING;
            end
            default: pend_vld = 1'b0;
        endcase

        sc_start = pos_reg;
        if (end_marker) begin
            sc_vld  = 1'b1;
            sc_kind = K_EOF;
            sc_len  = '0;
        end else begin
            sc_vld  = do_start && (cls == CC_SINGLE || cls == CC_BAD);
            sc_kind = (cls == CC_SINGLE) ? single_kind(char_code) : K_BADCHAR;
            sc_len  = POS_WIDTH'(1);
        end

        pend_tok = '{kind: pend_kind, start: out16(start_reg), length: out16(pend_len),
                     line: line_reg, last: 1'b0};
        sc_tok   = '{kind: sc_kind, start: out16(sc_start), length: out16(sc_len),
                     line: line_reg, last: 1'b1};

        emit.count = 2'(pend_vld) + 2'(sc_vld);
        emit.tok0  = pend_vld ? pend_tok : sc_tok;
        emit.tok1  = sc_tok;
        emit.tok0.last = !(pend_vld && sc_vld);
    end

    // State registers advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= SCAN_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            window_reg <= '0;
            line_reg   <= 16'd1;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            window_reg <= window_next;
            line_reg   <= line_next;
        end
    end

endmodule

@@ design/stok_outq.sv @@
// ============================================================================
// stok_outq: result queue
// Small register queue taking up to two tokens per cycle and handing one
// token per cycle to the result channel.
// ============================================================================
module stok_outq import stok_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  stok_emit_t wr_data,
    output logic       wr_ready,
    output logic       rd_valid,
    input  logic       rd_ready,
    output token_t     rd_tok
);

    token_t               entry_reg [QDEPTH];
    logic [Q_IDX_W-1:0]   head_reg, head_next;
    logic [Q_IDX_W-1:0]   tail_reg, tail_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic [1:0]           wr_n;
    logic                 rd_fire;

    // Room for the worst case of two tokens
    assign wr_ready = (count_reg <= Q_CNT_W'(QDEPTH - 2));
    assign rd_valid = (count_reg != '0);
    assign rd_tok   = entry_reg[head_reg];
    assign rd_fire  = rd_valid && rd_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_n       = wr_en ? wr_data.count : 2'd0;
        tail_next  = tail_reg + Q_IDX_W'(wr_n);
        head_next  = head_reg + Q_IDX_W'(rd_fire);
        count_next = count_reg + Q_CNT_W'(wr_n) - Q_CNT_W'(rd_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Token storage
    always_ff @(posedge aclk) begin
        if (wr_n != 2'd0) begin
            entry_reg[tail_reg] <= wr_data.tok0;
        end
        if (wr_n == 2'd2) begin
            entry_reg[tail_reg + Q_IDX_W'(1)] <= wr_data.tok1;
        end
    end

endmodule

@@ design/stok_checker.sv @@
// ============================================================================
// stok_checker: port-level checks for the source tokenizer
// Watches the token channel for reset behavior, stall hold and token shape.
// ============================================================================
module stok_checker import stok_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // Nothing is offered right after a reset cycle
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token offered after reset");

    // A stalled beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token changed");

    // End of file closes the run and has no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:0] == K_EOF |-> m_tlast && m_tdata[37:22] == 16'd0)
        else $error("bad end-of-file token");

    // Two-character operators always span two bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5:0] == K_ASSIGN || m_tdata[5:0] == K_EQEQ ||
                     m_tdata[5:0] == K_ARROW || m_tdata[5:0] == K_NE ||
                     m_tdata[5:0] == K_LE || m_tdata[5:0] == K_GE)
        |-> m_tdata[37:22] == 16'd2)
        else $error("operator pair length wrong");

    // A stray byte is reported as one character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:0] == K_BADCHAR |-> m_tdata[37:22] == 16'd1)
        else $error("bad-character token length wrong");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

@@ tb/sv/tb_source_tokenizer.sv @@
// ============================================================================
// tb_source_tokenizer: self-checking bench for the streaming tokenizer
// Source bytes go in on the slave stream. A lexer model in the bench works out
// the tokens that each accepted beat completes. Tokens that come out of the
// master stream are checked in order against it. Stimulus is a short directed
// text, then random texts built mostly from well-formed lexemes with noise
// mixed in.
// ============================================================================
module tb_source_tokenizer import stok_pkg::*;;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam int         RAND_BEATS = 1300;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } src_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;

    // Bench state
    src_beat_t   src_beats[$];
    token_t      tokens_due[$];
    token_t      step_toks[$];
    logic        s_took = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          mismatches = 0;
    int          tokens_seen = 0;
    int          cycles = 0;
    int          cycle_limit = 32'h7FFF_FFFF;

    // Lexer model state
    scan_mode_t  lx_mode;
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [15:0] lx_len;
    logic [15:0] lx_line;
    logic [31:0] lx_window;

    string punct_chars = "{}()[];&,|+*/%";
    string pair_chars  = ":=-!<>";
    string word_list[10] = '{"func", "ret", "if", "else", "fun", "rets", "iff",
                             "elsex", "el", "f_9"};

    source_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------
    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        case (c)
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            ";": return K_SEMI;
            "&": return K_AMP;
            ",": return K_COMMA;
            "|": return K_PIPE;
            "+": return K_PLUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "%": return K_PERCENT;
            default: return K_NONE;
        endcase
    endfunction

    // Operator characters that may pair with a following one
    function automatic logic [5:0] pair_kind(input logic [7:0] c);
        case (c)
            ":": return K_COLON;
            "=": return K_EQ;
            "-": return K_MINUS;
            "!": return K_BANG;
            "<": return K_LT;
            ">": return K_GT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] word_kind();
        if (lx_len == 16'd4 && lx_window == KW_FUNC) return K_FUNC;
        if (lx_len == 16'd3 && lx_window[23:0] == KW_RET) return K_RET;
        if (lx_len == 16'd2 && lx_window[15:0] == KW_IF) return K_IF;
        if (lx_len == 16'd4 && lx_window == KW_ELSE) return K_ELSE;
        return K_IDENT;
    endfunction

    task automatic lexer_clear();
        lx_mode   = SCAN_IDLE;
        lx_pos    = 16'd0;
        lx_start  = 16'd0;
        lx_len    = 16'd0;
        lx_window = 32'd0;
        lx_line   = 16'd1;
    endtask

    task automatic note_token(input logic [5:0] kind, input logic [15:0] start,
                              input logic [15:0] len);
        token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.line   = lx_line;
        t.last   = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endtask

    // First byte of a new lexeme, scanner idle
    task automatic open_lexeme(input logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (c == CH_NL && lx_line != LINE_MAX) lx_line = lx_line + 16'd1;
        end else if (punct_kind(c) != K_NONE) begin
            note_token(punct_kind(c), lx_pos, 16'd1);
        end else if (pair_kind(c) != K_NONE) begin
            lx_mode   = SCAN_OP;
            lx_start  = lx_pos;
            lx_window = 32'(pair_kind(c));
        end else if (c == CH_QUOTE) begin
            lx_mode  = SCAN_STR;
            lx_start = sat_up(lx_pos);
            lx_len   = 16'd0;
        end else if (is_letter(c) || is_digit(c)) begin
            lx_mode   = is_letter(c) ? SCAN_IDENT : SCAN_INT;
            lx_start  = lx_pos;
            lx_len    = 16'd1;
            lx_window = 32'(c);
        end else begin
            note_token(K_BADCHAR, lx_pos, 16'd1);
        end
    endtask

    // One accepted input beat: queue the tokens it completes
    task automatic scan_beat(input logic [7:0] c, input logic fin);
        logic [5:0] k;
        token_t     t;
        step_toks.delete();
        if (fin) begin
            case (lx_mode)
                SCAN_OP:    note_token(lx_window[5:0], lx_start, 16'd1);
                SCAN_IDENT: note_token(word_kind(), lx_start, lx_len);
                SCAN_INT:   note_token(K_INT, lx_start, lx_len);
                SCAN_STR:   note_token(K_UNTERM, lx_start, lx_len);
                default: ;
            endcase
            note_token(K_EOF, lx_pos, 16'd0);
            lexer_clear();
        end else begin
            case (lx_mode)
                SCAN_OP: begin
                    k = lx_window[5:0];
                    lx_mode   = SCAN_IDLE;
                    lx_window = 32'd0;
                    // '-' pairs with '>', the others with '='
                    if (c == ((k == K_MINUS) ? CH_GT : CH_EQ)) begin
                        note_token(k + 6'd1, lx_start, 16'd2);
                    end else begin
                        note_token(k, lx_start, 16'd1);
                        open_lexeme(c);
                    end
                end
                SCAN_IDENT: begin
                    if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                        lx_len    = sat_up(lx_len);
                        lx_window = {lx_window[23:0], c};
                    end else begin
                        note_token(word_kind(), lx_start, lx_len);
                        lx_mode = SCAN_IDLE;
                        open_lexeme(c);
                    end
                end
                SCAN_INT: begin
                    if (is_digit(c)) begin
                        lx_len = sat_up(lx_len);
                    end else begin
                        note_token(K_INT, lx_start, lx_len);
                        lx_mode = SCAN_IDLE;
                        open_lexeme(c);
                    end
                end
                SCAN_STR: begin
                    if (c == CH_QUOTE) begin
                        note_token(K_STRING, lx_start, lx_len);
                        lx_mode = SCAN_IDLE;
                    end else begin
                        lx_len = sat_up(lx_len);
                    end
                end
                default: begin
                    lx_mode = SCAN_IDLE;
                    open_lexeme(c);
                end
            endcase
            lx_pos = sat_up(lx_pos);
        end
        for (int i = 0; i < step_toks.size(); i++) begin
            t = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            tokens_due.insert(tokens_due.size(), t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c);
        src_beat_t b;
        b.ch  = c;
        b.fin = 1'b0;
        src_beats.insert(src_beats.size(), b);
    endtask

    task automatic add_end(input logic [7:0] c);
        src_beat_t b;
        b.ch  = c;
        b.fin = 1'b1;
        src_beats.insert(src_beats.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // String body byte: anything but the closing quote, newlines now and then
    function automatic logic [7:0] rand_str_byte();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) return CH_NL;
        c = 8'($urandom_range(0, 255));
        return (c == CH_QUOTE) ? CH_APOS : c;
    endfunction

    task automatic add_lexeme();
        logic [7:0] c;
        int         n;
        case ($urandom_range(0, 9))
            0: add_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
            1: begin
                c = pair_chars[$urandom_range(0, pair_chars.len() - 1)];
                add_byte(c);
                case ($urandom_range(0, 3))
                    0, 1: add_byte((c == CH_DASH) ? CH_GT : CH_EQ);
                    2: add_byte((c == CH_DASH) ? CH_EQ : CH_GT);
                    default: ;
                endcase
            end
            2, 9: add_text(word_list[$urandom_range(0, 9)]);
            3: begin
                add_byte(rand_letter());
                n = $urandom_range(0, 7);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: add_byte(rand_digit());
                        1: add_byte(CH_UNDERSCORE);
                        default: add_byte(rand_letter());
                    endcase
                end
            end
            4: begin
                n = $urandom_range(1, 6);
                repeat (n) add_byte(rand_digit());
            end
            5: begin
                add_byte(CH_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n) add_byte(rand_str_byte());
                if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
            end
            6: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    case ($urandom_range(0, 2))
                        0: add_byte(CH_NL);
                        1: add_byte(CH_SPACE);
                        default: add_byte(8'($urandom_range(9, 13)));
                    endcase
                end
            end
            7: add_byte(8'($urandom_range(0, 255)));
            default: begin
                // bytes that the lexer reports as bad characters
                case ($urandom_range(0, 4))
                    0: add_byte(CH_UNDERSCORE);
                    1: add_byte(8'h00);
                    2: add_byte(8'($urandom_range(128, 255)));
                    3: add_byte(8'h23);
                    default: add_byte(8'h7E);
                endcase
            end
        endcase
    endtask

    // One random text closed by an end beat; some end inside an open string
    task automatic add_random_text();
        int n;
        if ($urandom_range(0, 19) != 0) begin
            n = $urandom_range(1, 30);
            repeat (n) begin
                add_lexeme();
                if ($urandom_range(0, 1) == 0) add_byte(CH_SPACE);
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            add_byte(CH_QUOTE);
            n = $urandom_range(0, 4);
            repeat (n) add_byte(rand_str_byte());
        end
        add_end(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Driver: source beats and sink backpressure, changed on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        src_beat_t beat;
        logic      quiet;
        if (aresetn) begin
            // calm stretches, and a calm tail at the end of the run
            quiet = (src_beats.size() < 300) || (src_beats.size() % 1024 >= 768);
            if (!s_tvalid || s_took) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (src_beats.size() > 0 && !quiet &&
                             $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (src_beats.size() > 0) begin
                    beat = src_beats.pop_front();
                    s_tdata  <= beat.ch;
                    s_tlast  <= beat.fin;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check tokens, then feed accepted source beats to the model
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        token_t got;
        token_t want;
        s_took <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind   = m_tdata[5:0];
                got.start  = m_tdata[21:6];
                got.length = m_tdata[37:22];
                got.line   = m_tdata[53:38];
                got.last   = m_tlast;
                if (tokens_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("token %0d unexpected: kind %0d start %0d len %0d line %0d",
                                 tokens_seen, got.kind, got.start, got.length, got.line);
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("token %0d mismatch: exp kind %0d start %0d len %0d",
                                     tokens_seen, want.kind, want.start, want.length);
                            $display("    exp line %0d last %0d", want.line, want.last);
                            $display("    got kind %0d start %0d len %0d line %0d last %0d",
                                     got.kind, got.start, got.length, got.line, got.last);
                        end
                        mismatches++;
                    end
                end
                tokens_seen++;
            end
            if (s_tvalid && s_tready) scan_beat(s_tdata, s_tlast);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > cycle_limit) begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycles, tokens_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int goal;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        lexer_clear();

        // Directed: keyword, string with newline, bad bytes, every pair
        // operator in its paired form, integer, unterminated string at the end
        add_text("if\"a\nb\"");
        add_byte(CH_UNDERSCORE);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_text(":=->!=<=>===79\"q");
        add_end(8'hA5);

        // Random texts
        goal = src_beats.size() + RAND_BEATS;
        while (src_beats.size() < goal) add_random_text();

        cycle_limit = 16 * src_beats.size() + 20000;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (src_beats.size() != 0 || s_tvalid) @(posedge aclk);
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
